>>> rtl/pcmdm_pkg.sv
// Package for the PCM channel down-mixer: widths, register indexes,
// format codes and the frame record passed from the front to the back.
// No dependencies.
`default_nettype none

package pcmdm_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam int WORD_W = 32;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 36;
  localparam int CNT_W  = 4;
  localparam int OUT_W  = 16;
  localparam int FRAC_W = 24;
  localparam int PROD_W = 40;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd2;

  localparam logic [1:0] FMT_PCM16   = 2'd0;
  localparam logic [1:0] FMT_FLOAT32 = 2'd1;

  localparam logic [1:0] TGT_STEREO = 2'd2;

  localparam logic [14:0] SCALE_16 = 15'd32767;

  typedef struct packed {
    logic [1:0]       sample_format;
    logic [CNT_W-1:0] source_channels;
    logic [1:0]       target_channels;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_a;
    logic [SUM_W-1:0] sum_b;
    logic [CNT_W-1:0] cnt_a;
    logic [CNT_W-1:0] cnt_b;
    logic             copy_b;
    logic             is_float;
    logic             supported;
  } frame_t;

endpackage

`default_nettype wire

>>> rtl/pcmdm_if.sv
// Channel interfaces of the PCM channel down-mixer: sample input, result
// output and configuration writes. Depends on pcmdm_pkg.
`default_nettype none

interface pcmdm_sample_if import pcmdm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] sample_word;

  modport source (output valid, output sample_word, input ready);
  modport sink (input valid, input sample_word, output ready);
endinterface

interface pcmdm_result_if import pcmdm_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] left_sample;
  logic signed [OUT_W-1:0] right_sample;
  logic                    format_error;

  modport source (output valid, output left_sample, output right_sample,
                  output format_error, input ready);
  modport sink (input valid, input left_sample, input right_sample,
                input format_error, output ready);
endinterface

interface pcmdm_cfg_if import pcmdm_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/pcmdm_front.sv
// Front end of the down-mixer: converts each sample item, accumulates the
// left, right and total sums and emits one frame record per finished frame.
// Depends on pcmdm_pkg and pcmdm_if.
`default_nettype none

module pcmdm_front import pcmdm_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  pcmdm_sample_if.sink  samples,
  input  cfg_t          cfg,
  output frame_t        push_frame,
  output logic          push_valid,
  input  logic          push_ready
);

  localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [7:0] EXP_UNIT = 8'd126;
  localparam logic [7:0] EXP_SAT  = 8'd134;
  localparam logic [7:0] EXP_MAX  = 8'hFF;

  function automatic logic [VAL_W-1:0] float_to_q824(input logic [WORD_W-1:0] w);
    logic              neg;
    logic [7:0]        e;
    logic [22:0]       fr;
    logic [23:0]       sig;
    logic [30:0]       mag;
    logic [7:0]        rsh;
    logic [2:0]        lsh;
    logic [VAL_W-1:0]  res;
    neg = w[31];
    e   = w[30:23];
    fr  = w[22:0];
    sig = {1'b1, fr};
    lsh = 3'(e - EXP_UNIT);
    rsh = EXP_UNIT - e;
    mag = '0;
    if (e == EXP_MAX && fr != '0) begin
      res = '0;
    end else if (e == '0) begin
      res = '0;
    end else if (e >= EXP_SAT) begin
      res = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      if (e >= EXP_UNIT) begin
        mag = 31'(sig) << lsh;
      end else if (rsh >= 8'd24) begin
        mag = '0;
      end else begin
        mag = 31'(sig >> rsh[4:0]);
      end
      res = neg ? (~{1'b0, mag} + 32'd1) : {1'b0, mag};
    end
    return res;
  endfunction

  logic             cv_valid;
  logic [VAL_W-1:0] cv_value;
  logic [POS_W-1:0] pos;
  logic [SUM_W-1:0] left_sum;
  logic [SUM_W-1:0] right_sum;
  logic [SUM_W-1:0] total_sum;

  logic             is_float;
  logic             supported;
  logic             stereo;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W:0]   pos_inc;
  logic             last;
  logic             acc_fire;
  logic             in_fire;
  logic [SUM_W-1:0] v_ext;
  logic [SUM_W-1:0] left_next;
  logic [SUM_W-1:0] right_next;
  logic [SUM_W-1:0] total_next;
  logic [CNT_W:0]   n_plus;

  always_comb begin
    is_float  = (cfg.sample_format == FMT_FLOAT32);
    supported = (cfg.sample_format == FMT_PCM16) || is_float;
    stereo    = (cfg.target_channels >= TGT_STEREO);
    if (cfg.source_channels == '0) begin
      n_eff = CNT_W'(1);
    end else if ({1'b0, cfg.source_channels} > (CNT_W+1)'(MAX_CHANNELS)) begin
      n_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      n_eff = cfg.source_channels;
    end
    pos_inc = (CNT_W+1)'(pos) + (CNT_W+1)'(1);
    last    = pos_inc >= {1'b0, n_eff};
    acc_fire = cv_valid && (!last || push_ready);
    in_fire  = samples.valid && samples.ready;

    v_ext = {{(SUM_W-VAL_W){cv_value[VAL_W-1]}}, cv_value};
    left_next  = left_sum;
    right_next = right_sum;
    total_next = total_sum;
    if (supported) begin
      total_next = total_sum + v_ext;
      if (!pos[0]) begin
        left_next = left_sum + v_ext;
      end else begin
        right_next = right_sum + v_ext;
      end
    end

    n_plus = {1'b0, n_eff} + (CNT_W+1)'(1);
    push_valid           = cv_valid && last;
    push_frame.sum_a     = stereo ? left_next : total_next;
    push_frame.sum_b     = right_next;
    push_frame.cnt_a     = stereo ? n_plus[CNT_W:1] : n_eff;
    push_frame.cnt_b     = {1'b0, n_eff[CNT_W-1:1]};
    push_frame.copy_b    = !stereo || (n_eff == CNT_W'(1));
    push_frame.is_float  = is_float;
    push_frame.supported = supported;
  end

  assign samples.ready = !cv_valid || acc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv_valid  <= 1'b0;
      pos       <= '0;
      left_sum  <= '0;
      right_sum <= '0;
      total_sum <= '0;
    end else begin
      if (in_fire) begin
        cv_valid <= 1'b1;
      end else if (acc_fire) begin
        cv_valid <= 1'b0;
      end
      if (acc_fire) begin
        if (last) begin
          pos       <= '0;
          left_sum  <= '0;
          right_sum <= '0;
          total_sum <= '0;
        end else begin
          pos       <= POS_W'(pos_inc);
          left_sum  <= left_next;
          right_sum <= right_next;
          total_sum <= total_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cv_value <= is_float ? float_to_q824(samples.sample_word)
                           : {{(VAL_W-16){samples.sample_word[15]}},
                              samples.sample_word[15:0]};
    end
  end

endmodule

`default_nettype wire

>>> rtl/pcmdm_fifo.sv
// Short first-in first-out queue of frame records between the front and
// the back of the down-mixer. No dependencies.
`default_nettype none

module pcmdm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = store[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pcmdm_back.sv
// Back end of the down-mixer: divides both sums of a frame record by their
// channel counts bit-serially, scales or saturates, and holds the result.
// Depends on pcmdm_pkg and pcmdm_if.
`default_nettype none

module pcmdm_back import pcmdm_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  frame_t          pop_frame,
  input  logic            pop_ready,
  output logic            pop,
  pcmdm_result_if.source  results
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam logic [FRAC_W:0] ONE_Q = (FRAC_W+1)'(1) << FRAC_W;
  localparam logic [PROD_W-1:0] HALF_Q = PROD_W'(1) << (FRAC_W - 1);
  localparam logic [OUT_W-1:0] POS_MAX = 16'h7FFF;
  localparam logic [OUT_W-1:0] NEG_MIN = 16'h8000;

  logic [1:0]        state;
  logic [STEP_W-1:0] step;
  logic              is_float;
  logic              supported;
  logic              copy_b;
  logic              sign [2];
  logic [SUM_W-1:0]  quo [2];
  logic [CNT_W-1:0]  rem [2];
  logic [CNT_W-1:0]  dvs [2];
  logic [PROD_W-1:0] prod [2];

  logic [CNT_W:0]    rem_sh [2];
  logic              ge [2];
  logic [CNT_W-1:0]  rem_step [2];
  logic [SUM_W-1:0]  quo_step [2];
  logic [FRAC_W:0]   clip [2];
  logic [PROD_W-1:0] rnd [2];
  logic [OUT_W-1:0]  mag16 [2];
  logic [OUT_W-1:0]  res [2];
  logic              out_load;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem_sh[i]   = {rem[i], quo[i][SUM_W-1]};
      ge[i]       = rem_sh[i] >= {1'b0, dvs[i]};
      rem_step[i] = ge[i] ? CNT_W'(rem_sh[i] - {1'b0, dvs[i]}) : rem_sh[i][CNT_W-1:0];
      quo_step[i] = {quo[i][SUM_W-2:0], ge[i]};
      clip[i]     = (quo[i] > SUM_W'(ONE_Q)) ? ONE_Q : quo[i][FRAC_W:0];
      rnd[i]      = prod[i] + HALF_Q;
      mag16[i]    = {1'b0, rnd[i][FRAC_W+14:FRAC_W]};
      if (is_float) begin
        res[i] = sign[i] ? (~mag16[i] + OUT_W'(1)) : mag16[i];
      end else if (sign[i]) begin
        res[i] = (quo[i] > SUM_W'(NEG_MIN)) ? NEG_MIN : (~quo[i][OUT_W-1:0] + OUT_W'(1));
      end else begin
        res[i] = (quo[i] > SUM_W'(POS_MAX)) ? POS_MAX : quo[i][OUT_W-1:0];
      end
    end
    pop      = (state == ST_IDLE) && pop_ready;
    out_load = (state == ST_OUT) && (!results.valid || results.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      results.valid <= 1'b0;
    end else begin
      if (out_load) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop_ready) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == STEP_W'(SUM_W - 1)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      is_float  <= pop_frame.is_float;
      supported <= pop_frame.supported;
      copy_b    <= pop_frame.copy_b;
      step      <= '0;
      sign[0]   <= pop_frame.sum_a[SUM_W-1];
      sign[1]   <= pop_frame.sum_b[SUM_W-1];
      quo[0]    <= pop_frame.sum_a[SUM_W-1] ? (~pop_frame.sum_a + SUM_W'(1)) : pop_frame.sum_a;
      quo[1]    <= pop_frame.sum_b[SUM_W-1] ? (~pop_frame.sum_b + SUM_W'(1)) : pop_frame.sum_b;
      rem[0]    <= '0;
      rem[1]    <= '0;
      dvs[0]    <= pop_frame.cnt_a;
      dvs[1]    <= pop_frame.cnt_b;
    end else if (state == ST_DIV) begin
      step <= step + STEP_W'(1);
      for (int i = 0; i < 2; i++) begin
        rem[i] <= rem_step[i];
        quo[i] <= quo_step[i];
      end
    end
    if (state == ST_MUL) begin
      for (int i = 0; i < 2; i++) begin
        prod[i] <= PROD_W'(clip[i]) * PROD_W'(SCALE_16);
      end
    end
    if (out_load) begin
      results.left_sample  <= supported ? res[0] : '0;
      results.right_sample <= supported ? (copy_b ? res[0] : res[1]) : '0;
      results.format_error <= !supported;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pcm_channel_downmixer_core.sv
// Top level of the PCM channel down-mixer: configuration registers, front
// end, frame queue and back end. Depends on pcmdm_pkg, pcmdm_if,
// pcmdm_front, pcmdm_fifo and pcmdm_back.
//
// The block takes one interleaved sample item per cycle while the frame
// queue has room, and returns one 16-bit mono or stereo result item at the
// end of each source frame. The front end registers the converted sample
// and then adds it into the sum registers, pipelined, so samples enter back
// to back. Each finished frame is loaded into the back end, passes through
// the bit-serial divider (one quotient bit per cycle, both channels in
// parallel), the scaling multiply and the output register load. The back
// end takes no new frame until the last one has reached the output
// register, with a queue of QUEUE_DEPTH frames absorbing bursts.
// Configuration is taken at any time, one write per cycle, and must only
// change while the block is idle.
`default_nettype none

module pcm_channel_downmixer_core import pcmdm_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  pcmdm_cfg_if.sink       cfg,
  pcmdm_sample_if.sink    samples,
  pcmdm_result_if.source  results
);

  localparam int FRAME_W = $bits(frame_t);

  cfg_t               cfg_regs;
  frame_t             push_frame;
  logic               push_valid;
  logic               push_full;
  logic [FRAME_W-1:0] pop_data;
  logic               pop_empty;
  logic               pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.sample_format   <= FMT_PCM16;
      cfg_regs.source_channels <= CNT_W'(2);
      cfg_regs.target_channels <= TGT_STEREO;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_FORMAT: cfg_regs.sample_format   <= cfg.data[1:0];
        CFG_SOURCE: cfg_regs.source_channels <= cfg.data[CNT_W-1:0];
        CFG_TARGET: cfg_regs.target_channels <= cfg.data[1:0];
        default: begin
        end
      endcase
    end
  end

  pcmdm_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .cfg        (cfg_regs),
    .push_frame (push_frame),
    .push_valid (push_valid),
    .push_ready (!push_full)
  );

  pcmdm_fifo #(
    .WIDTH(FRAME_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_data (push_frame),
    .full      (push_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (pop_empty)
  );

  pcmdm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_frame (frame_t'(pop_data)),
    .pop_ready (!pop_empty),
    .pop       (pop),
    .results   (results)
  );

endmodule

`default_nettype wire

>>> rtl/pcmdm_checker.sv
// Port-level checks for the PCM channel down-mixer and the bind that
// attaches them to the top level. Depends on pcmdm_pkg.
`default_nettype none

module pcmdm_checker import pcmdm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [OUT_W-1:0]      res_left,
  input logic [OUT_W-1:0]      res_right,
  input logic                  res_error
);

  logic [1:0]       fmt;
  logic [CNT_W-1:0] src;
  logic [1:0]       tgt;
  logic             fmt_bad;
  logic             copy_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_PCM16;
      src <= CNT_W'(2);
      tgt <= TGT_STEREO;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FORMAT) begin
        fmt <= cfg_data[1:0];
      end
      if (cfg_index == CFG_SOURCE) begin
        src <= cfg_data[CNT_W-1:0];
      end
      if (cfg_index == CFG_TARGET) begin
        tgt <= cfg_data[1:0];
      end
    end
  end

  assign fmt_bad   = (fmt != FMT_PCM16) && (fmt != FMT_FLOAT32);
  assign copy_mode = (tgt < TGT_STEREO) || (src <= CNT_W'(1));

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_left) &&
      $stable(res_right) && $stable(res_error))
    else $error("stalled result item changed");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_error |-> res_left == '0 && res_right == '0)
    else $error("format error with nonzero samples");

  a_error_matches: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_error == fmt_bad)
    else $error("format error flag disagrees with configured format");

  a_copy_right: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_error && copy_mode |-> res_left == res_right)
    else $error("right sample differs from left in mono or single-source mode");

endmodule

bind pcm_channel_downmixer_core pcmdm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg.valid),
  .cfg_ready (cfg.ready),
  .cfg_index (cfg.index),
  .cfg_data  (cfg.data),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_left  (results.left_sample),
  .res_right (results.right_sample),
  .res_error (results.format_error)
);

`default_nettype wire

>>> tb/pcm_channel_downmixer_core_test.sv
// Testbench for pcm_channel_downmixer_core: directed table, then random phases
// of configuration and interleaved samples, with results checked against a
// local down-mix predictor. Depends on pcmdm_pkg, the pcmdm interfaces and the RTL.
`timescale 1ns / 100ps

module pcm_channel_downmixer_core_test import pcmdm_pkg::*;;

  localparam int MAX_CH      = MAX_CHANNELS_DEF;
  localparam int DRAIN       = 120;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 1600;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [1:0] FMT_BAD_A = 2'd2;
  localparam logic [1:0] FMT_BAD_B = 2'd3;
  localparam logic [1:0] TGT_ZERO  = 2'd0;
  localparam logic [1:0] TGT_MONO  = 2'd1;
  localparam logic [1:0] TGT_WIDE  = 2'd3;

  typedef struct packed {
    logic signed [OUT_W-1:0] left_sample;
    logic signed [OUT_W-1:0] right_sample;
    logic                    format_error;
  } mix_t;

  typedef struct {
    bit   typed;
    mix_t val;
  } tag_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [WORD_W-1:0]     word;
    bit                    typed;
    mix_t                  val;
  } row_t;

  logic clk;
  logic rst;

  pcmdm_cfg_if    cfg_ch ();
  pcmdm_sample_if smp_ch ();
  pcmdm_result_if res_ch ();

  pcm_channel_downmixer_core u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (smp_ch),
    .results (res_ch)
  );

  logic [1:0]       fmt_reg;
  logic [CNT_W-1:0] src_reg;
  logic [1:0]       tgt_reg;
  longint           left_acc;
  longint           right_acc;
  int               frame_pos;

  mix_t frame_q[$];
  tag_t tag_q[$];
  row_t plan[$];

  int err_count;
  int idle_cycles;
  int smp_quiet;
  int res_quiet;
  int items_sent;

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  function automatic longint float_q824(logic [31:0] w);
    int          ei;
    logic [63:0] sig;
    logic [63:0] mag;
    ei = int'(w[30:23]);
    sig = {40'd0, 1'b1, w[22:0]};
    if (ei == 255 && w[22:0] != 0) return 0;
    if (ei == 0) return 0;
    if (ei >= 134) return w[31] ? -64'sd2147483648 : 64'sd2147483647;
    if (ei >= 126) mag = sig << (ei - 126);
    else if (126 - ei >= 32) mag = 0;
    else mag = sig >> (126 - ei);
    if (!w[31] && mag > 64'd2147483647) mag = 64'd2147483647;
    return w[31] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [OUT_W-1:0] average_out(longint sum, longint cnt,
                                                          bit is_flt);
    longint avg;
    longint mag;
    longint q;
    avg = sum / cnt;
    if (!is_flt) begin
      if (avg > 32767) avg = 32767;
      if (avg < -32768) avg = -32768;
      return avg[OUT_W-1:0];
    end
    q = avg;
    if (q > (64'sd1 << 24)) q = 64'sd1 << 24;
    if (q < -(64'sd1 << 24)) q = -(64'sd1 << 24);
    mag = (q < 0) ? -q : q;
    mag = (mag * 32767 + (64'sd1 << 23)) >>> 24;
    q = (q < 0) ? -mag : mag;
    return q[OUT_W-1:0];
  endfunction

  task automatic downmix_step(input logic [WORD_W-1:0] w, output bit done,
                              output mix_t res);
    int     n;
    bit     is_flt;
    bit     ok;
    bit     stereo;
    longint v;
    n = int'(src_reg);
    if (n < 1) n = 1;
    if (n > MAX_CH) n = MAX_CH;
    is_flt = (fmt_reg == FMT_FLOAT32);
    ok = (fmt_reg <= FMT_FLOAT32);
    stereo = (tgt_reg >= TGT_STEREO);
    res = '0;
    done = 1'b0;
    if (is_flt) v = float_q824(w);
    else v = longint'($signed(w[15:0]));
    if (ok) begin
      if (frame_pos[0] == 1'b0) left_acc += v;
      else right_acc += v;
    end
    if (frame_pos + 1 < n) begin
      frame_pos++;
    end else begin
      if (ok && !stereo) begin
        res.left_sample = average_out(left_acc + right_acc, n, is_flt);
        res.right_sample = res.left_sample;
      end else if (ok) begin
        res.left_sample = average_out(left_acc, (n + 1) / 2, is_flt);
        res.right_sample = (n / 2 == 0) ? res.left_sample
                                        : average_out(right_acc, n / 2, is_flt);
      end
      res.format_error = !ok;
      left_acc = 0;
      right_acc = 0;
      frame_pos = 0;
      done = 1'b1;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : monitor
    bit   done;
    bit   seen;
    mix_t pred;
    mix_t want;
    tag_t tag;
    seen = 1'b0;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        seen = 1'b1;
        case (cfg_ch.index)
          CFG_FORMAT: fmt_reg = cfg_ch.data[1:0];
          CFG_SOURCE: src_reg = cfg_ch.data;
          CFG_TARGET: tgt_reg = cfg_ch.data[1:0];
          default: ;
        endcase
      end
      if (smp_ch.valid && smp_ch.ready) begin
        seen = 1'b1;
        tag = tag_q.pop_front();
        downmix_step(smp_ch.sample_word, done, pred);
        if (done) frame_q.insert(frame_q.size(), tag.typed ? tag.val : pred);
      end
      if (res_ch.valid && res_ch.ready) begin
        seen = 1'b1;
        if (frame_q.size() == 0) begin
          report_mismatch("result with none pending", res_ch.left_sample, 0);
        end else begin
          want = frame_q.pop_front();
          if (res_ch.left_sample !== want.left_sample)
            report_mismatch("left_sample", res_ch.left_sample, want.left_sample);
          if (res_ch.right_sample !== want.right_sample)
            report_mismatch("right_sample", res_ch.right_sample, want.right_sample);
          if (res_ch.format_error !== want.format_error)
            report_mismatch("format_error", res_ch.format_error, want.format_error);
        end
      end
    end
    idle_cycles = seen ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic draw_wait(inout int quiet, output int n);
    if (quiet > 0) begin
      quiet--;
      n = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(8, 40);
      n = 0;
    end else begin
      n = $urandom_range(0, 8);
    end
  endtask

  initial begin : result_sink
    int n;
    res_ch.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      draw_wait(res_quiet, n);
      if (n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  task automatic send_sample(logic [WORD_W-1:0] w, bit typed, mix_t val);
    int   n;
    tag_t tag;
    tag.typed = typed;
    tag.val = val;
    draw_wait(smp_quiet, n);
    if (n > 0) begin
      smp_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    smp_ch.valid <= 1'b1;
    smp_ch.sample_word <= w;
    tag_q.insert(tag_q.size(), tag);
    @(posedge clk);
    while (!smp_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    smp_ch.valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    row_t r;
    r = '{1'b1, idx, data, '0, 1'b0, '0};
    plan.insert(plan.size(), r);
  endtask

  task automatic add_smp(logic [WORD_W-1:0] w);
    row_t r;
    r = '{1'b0, '0, '0, w, 1'b0, '0};
    plan.insert(plan.size(), r);
  endtask

  task automatic add_chk(logic [WORD_W-1:0] w, int l, int r, bit e);
    row_t row;
    row = '{1'b0, '0, '0, w, 1'b1, '0};
    row.val.left_sample = l[OUT_W-1:0];
    row.val.right_sample = r[OUT_W-1:0];
    row.val.format_error = e;
    plan.insert(plan.size(), row);
  endtask

  function automatic logic [WORD_W-1:0] rand_word(logic [1:0] fmt);
    logic [WORD_W-1:0] w;
    int                k;
    w = $urandom;
    k = $urandom_range(0, 9);
    if (fmt == FMT_FLOAT32) begin
      case (k)
        0: ;
        1: w = {w[31], 8'h00, w[22:0]};
        2: w = {w[31], 8'hFF, 23'd0};
        3: w = {w[31], 8'hFF, w[22:1], 1'b1};
        4: w = {w[31], 8'd127, 23'd0};
        5: w = {w[31], 8'($urandom_range(126, 140)), w[22:0]};
        default: w = {w[31], 8'($urandom_range(100, 133)), w[22:0]};
      endcase
    end else begin
      case (k)
        0: w[15:0] = 16'h7FFF;
        1: w[15:0] = 16'h8000;
        default: ;
      endcase
    end
    return w;
  endfunction

  initial begin : stimulus
    bit                    prev_cfg;
    int                    count;
    int                    pick;
    logic [1:0]            fmt;
    logic [CFG_DATA_W-1:0] src;
    logic [1:0]            tgt;
    mix_t                  none;

    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    smp_ch.valid = 1'b0;
    smp_ch.sample_word = '0;
    fmt_reg = FMT_PCM16;
    src_reg = 4'd2;
    tgt_reg = TGT_STEREO;
    left_acc = 0;
    right_acc = 0;
    frame_pos = 0;
    err_count = 0;
    idle_cycles = 0;
    smp_quiet = 0;
    res_quiet = 0;
    items_sent = 0;
    none = '0;

    add_smp(32'h0000_7FFF);
    add_chk(32'hFFFF_8000, 32767, -32768, 1'b0);
    add_smp(32'h1234_FFFF);
    add_chk(32'h0000_0001, -1, 1, 1'b0);
    add_cfg(CFG_SOURCE, 4'd1);
    add_chk(32'h0000_8000, -32768, -32768, 1'b0);
    add_cfg(CFG_TARGET, {2'b00, TGT_MONO});
    add_smp(32'h5A5A_ABCD);
    add_cfg(CFG_FORMAT, {2'b00, FMT_FLOAT32});
    add_cfg(CFG_SOURCE, 4'd4);
    add_cfg(CFG_TARGET, {2'b00, TGT_STEREO});
    add_smp(32'h3F80_0000);
    add_smp(32'hBF80_0000);
    add_smp(32'h7F80_0000);
    add_smp(32'h7FC0_0000);
    add_cfg(CFG_SOURCE, 4'd2);
    add_smp(32'h0000_0001);
    add_smp(32'hFF80_0000);
    add_cfg(CFG_FORMAT, {2'b00, FMT_BAD_A});
    add_smp(32'h0000_7FFF);
    add_chk(32'h8000_8000, 0, 0, 1'b1);
    add_cfg(CFG_FORMAT, {2'b11, FMT_BAD_B});
    add_cfg(CFG_SOURCE, 4'd0);
    add_cfg(CFG_TARGET, {2'b11, TGT_WIDE});
    add_cfg(CFG_SPARE, 4'hF);
    add_chk(32'hFFFF_FFFF, 0, 0, 1'b1);
    add_cfg(CFG_FORMAT, {2'b00, FMT_PCM16});
    add_cfg(CFG_SOURCE, 4'd3);
    add_cfg(CFG_TARGET, {2'b00, TGT_STEREO});
    add_smp(32'h0000_0100);
    add_cfg(CFG_SOURCE, 4'd2);
    add_smp(32'h0000_0200);
    add_cfg(CFG_SOURCE, 4'd9);
    add_cfg(CFG_TARGET, {2'b00, TGT_ZERO});
    for (int i = 0; i < 8; i++) add_smp(i[0] ? 32'h0000_7FFF : 32'hFFFF_7FFF);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    prev_cfg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!prev_cfg) wait_idle();
        cfg_write(plan[i].idx, plan[i].data);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_ch.valid <= 1'b0;
        send_sample(plan[i].word, plan[i].typed, plan[i].val);
        prev_cfg = 1'b0;
      end
    end

    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      pick = $urandom_range(0, 19);
      fmt = (pick < 9) ? FMT_PCM16 : (pick < 18) ? FMT_FLOAT32
                                                 : ($urandom_range(0, 1) ? FMT_BAD_A
                                                                         : FMT_BAD_B);
      src = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                        : 4'($urandom_range(1, 8));
      tgt = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? TGT_ZERO : TGT_WIDE)
                                        : ($urandom_range(0, 1) ? TGT_MONO : TGT_STEREO);
      cfg_write(CFG_FORMAT, {2'($urandom_range(0, 3)), fmt});
      cfg_write(CFG_SOURCE, src);
      cfg_write(CFG_TARGET, {2'($urandom_range(0, 3)), tgt});
      if ($urandom_range(0, 7) == 0) cfg_write(CFG_SPARE, 4'($urandom_range(0, 15)));
      cfg_ch.valid <= 1'b0;
      count = $urandom_range(8, 60);
      for (int i = 0; i < count; i++) send_sample(rand_word(fmt), 1'b0, none);
    end

    smp_ch.valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/pcmdm_pkg.sv
rtl/pcmdm_if.sv
rtl/pcmdm_front.sv
rtl/pcmdm_fifo.sv
rtl/pcmdm_back.sv
rtl/pcm_channel_downmixer_core.sv
rtl/pcmdm_checker.sv
tb/pcm_channel_downmixer_core_test.sv
